// ===== rtl/awm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package awm_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int WEEK_W   = 3;
	localparam int ANCHOR_W = 3;
	localparam int WD_W     = 3;
	localparam int BY_W     = 15;
	localparam int Q_W      = 8;
	localparam int PROD_W   = 26;
	localparam int RECIP_SH = 18;

	localparam logic [ANCHOR_W-1:0] ANCHOR_RESET = 3'd1;
	// biased year minus one: the weekday terms are taken on the year before
	localparam logic [BY_W-1:0]     YEAR_BIAS_M1 = 15'd399;
	// ceil(2^18 / 25), exact for the quarter-year range used here
	localparam logic [PROD_W-1:0]   RECIP25      = 26'd10486;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic [BY_W-1:0]    y1;
		logic [Q_W-1:0]     q100;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} yr_s1_t;

	typedef struct packed {
		logic [BY_W-1:0]    ysum;
		logic               leap;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} yr_s2_t;

	typedef struct packed {
		logic [WD_W-1:0]  w_cur;
		logic [WD_W-1:0]  w_next;
		logic [WD_W-1:0]  w_prev;
		logic [DAY_W-1:0] dim;
		logic [DAY_W-1:0] plen_days;
		logic [DAY_W-1:0] day;
		logic             bad;
	} cal_t;

	// octal digit folding, 8 = 1 mod 7
	function automatic logic [WD_W-1:0] mod7(input logic [BY_W-1:0] s);
		logic [5:0] o;
		logic [3:0] o2;
		o  = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
		o2 = 4'(o[2:0]) + 4'(o[5:3]);
		return (o2 >= 4'd7) ? 3'(o2 - 4'd7) : o2[2:0];
	endfunction

	function automatic logic [WD_W-1:0] month_key(input logic [MONTH_W-1:0] m);
		logic [WD_W-1:0] k;
		unique case (m)
			4'd1:    k = 3'd0;
			4'd2:    k = 3'd3;
			4'd3:    k = 3'd2;
			4'd4:    k = 3'd5;
			4'd5:    k = 3'd0;
			4'd6:    k = 3'd3;
			4'd7:    k = 3'd5;
			4'd8:    k = 3'd1;
			4'd9:    k = 3'd4;
			4'd10:   k = 3'd6;
			4'd11:   k = 3'd2;
			4'd12:   k = 3'd4;
			default: k = 3'd0;
		endcase
		return k;
	endfunction

	// zero for a month code outside 1..12
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:    n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	// weekday of the 1st, 1=Mon..7=Sun
	function automatic logic [WD_W-1:0] first_wday(input logic [WD_W-1:0] t,
			input logic [WD_W-1:0] key);
		logic [3:0] s;
		logic [3:0] r;
		s = 4'(t) + 4'(key) + 4'd1;
		r = (s >= 4'd7) ? (s - 4'd7) : s;
		return (r == 4'd0) ? 3'd7 : r[2:0];
	endfunction

	// calendar row of a day, first row holds flen days; divide by 7 as *37 >> 8
	function automatic logic [WD_W-1:0] row_of(input logic [DAY_W-1:0] d,
			input logic [3:0] flen);
		logic [5:0]  x;
		logic [10:0] p;
		x = 6'(d) - 6'(flen) + 6'd6;
		p = 11'(x) * 11'd37;
		return (6'(d) <= 6'(flen)) ? 3'd0 : p[10:8];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/awm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface awm_date_if import awm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day;

	modport source (output valid, output year, output month, output day, input ready);
	modport sink (input valid, input year, input month, input day, output ready);
endinterface

interface awm_week_if import awm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WEEK_W-1:0] week_number;
	logic              invalid;

	modport source (output valid, output week_number, output invalid, input ready);
	modport sink (input valid, input week_number, input invalid, output ready);
endinterface

`default_nettype wire

// ===== rtl/awm_year.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awm_year import awm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               dn_valid,
	input  logic               dn_ready,
	output yr_s2_t             dn_data
);

	logic   v_s1, v_s2;
	logic   rdy_s1, rdy_s2;
	yr_s1_t d_s1;
	yr_s2_t d_s2;

	logic [BY_W-1:0]   y1;
	logic [PROD_W-1:0] prod;
	logic [BY_W-1:0]   rem100;
	logic              leap;
	logic [BY_W-1:0]   ysum;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;
	assign dn_valid = v_s2;
	assign dn_data  = d_s2;

	// stage 1: year before the biased year, and its hundreds by reciprocal
	assign y1   = BY_W'(year) + YEAR_BIAS_M1;
	assign prod = PROD_W'(y1[BY_W-1:2]) * RECIP25;

	// stage 2: leap flag of the biased year, and the Sakamoto year sum
	assign rem100 = d_s1.y1 - BY_W'(d_s1.q100) * 15'd100;
	assign leap   = (d_s1.y1[1:0] == 2'b11 && rem100 != 15'd99) ||
		(rem100 == 15'd99 && d_s1.q100[1:0] == 2'b11);
	assign ysum   = d_s1.y1 + BY_W'(d_s1.y1[BY_W-1:2]) - BY_W'(d_s1.q100)
		+ BY_W'(d_s1.q100[Q_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= up_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			d_s1.y1    <= y1;
			d_s1.q100  <= prod[PROD_W-1:RECIP_SH];
			d_s1.month <= month;
			d_s1.day   <= day;
		end
		if (rdy_s2 && v_s1) begin
			d_s2.ysum  <= ysum;
			d_s2.leap  <= leap;
			d_s2.month <= d_s1.month;
			d_s2.day   <= d_s1.day;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/awm_cal.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awm_cal import awm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_ready,
	input  yr_s2_t up_data,
	output logic   dn_valid,
	input  logic   dn_ready,
	output cal_t   dn_data
);

	logic v_s3;
	cal_t d_s3;
	cal_t nxt;

	logic [WD_W-1:0]    t0, t1;
	logic [3:0]         t1_sum;
	logic [MONTH_W-1:0] m, m_next, m_prev;

	assign up_ready = !v_s3 || dn_ready;
	assign dn_valid = v_s3;
	assign dn_data  = d_s3;

	assign m      = up_data.month;
	assign m_next = (m == MON_DEC) ? MON_JAN : m + 4'd1;
	assign m_prev = (m == MON_JAN) ? MON_DEC : m - 4'd1;

	// t0: year term of the year before, t1: of the year itself
	assign t0     = mod7(up_data.ysum);
	assign t1_sum = 4'(t0) + 4'd1 + 4'(up_data.leap);
	assign t1     = (t1_sum >= 4'd7) ? 3'(t1_sum - 4'd7) : t1_sum[2:0];

	always_comb begin
		nxt.w_cur     = first_wday((m < MON_MAR) ? t0 : t1, month_key(m));
		nxt.w_next    = first_wday((m == MON_JAN) ? t0 : t1, month_key(m_next));
		nxt.w_prev    = first_wday((m <= MON_MAR) ? t0 : t1, month_key(m_prev));
		nxt.dim       = month_days(m, up_data.leap);
		nxt.plen_days = month_days(m_prev, up_data.leap);
		nxt.day       = up_data.day;
		nxt.bad       = (m == 4'd0) || (m > MON_DEC) || (up_data.day == 5'd0) ||
			(up_data.day > nxt.dim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (up_ready)
			v_s3 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			d_s3 <= nxt;
	end

endmodule

`default_nettype wire

// ===== rtl/awm_week.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awm_week import awm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ANCHOR_W-1:0] anchor,
	input  logic                up_valid,
	output logic                up_ready,
	input  cal_t                up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output logic [WEEK_W-1:0]   week_number,
	output logic                invalid
);

	logic              v_s4;
	logic [WEEK_W-1:0] week_s4;
	logic              inv_s4;

	logic [3:0]        thr, flen, plen;
	logic [WD_W-1:0]   row, prow;
	logic              bad, last_wrap;
	logic [WEEK_W-1:0] week;

	assign up_ready    = !v_s4 || dn_ready;
	assign dn_valid    = v_s4;
	assign week_number = week_s4;
	assign invalid     = inv_s4;

	assign thr  = 4'd8 - 4'(anchor);
	assign flen = 4'd8 - 4'(up_data.w_cur);
	assign plen = 4'd8 - 4'(up_data.w_prev);
	assign row  = row_of(up_data.day, flen);
	assign prow = row_of(up_data.plen_days, plen);

	assign bad       = up_data.bad || (anchor == 3'd0);
	// last day of the month with the next month starting on the anchor
	assign last_wrap = (up_data.day == up_data.dim) && (up_data.w_next == anchor);

	always_comb begin
		priority if (bad)
			week = 3'd0;
		else if (last_wrap)
			week = 3'd1;
		else if (flen < thr) begin
			if (row == 3'd0)
				week = prow + 3'd1 - 3'(plen < thr);
			else
				week = row;
		end else
			week = row + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (up_ready)
			v_s4 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			week_s4 <= week;
			inv_s4  <= bad;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/anchored_week_of_month.sv =====
// Anchored week-of-month: one date word in, one week word out. Four register
// stages (year offset and hundreds by reciprocal multiply, leap flag and year
// sum, weekdays of the 1st for this, next and previous month, week select);
// a new date can be taken every cycle unless every stage is full and the
// output is stalled. Each stage has its own valid and stall, so bubbles are
// squeezed out while the output word waits. anchor_q resets to 1 (Monday); the
// user must write it through anchor_we/anchor_wdata only while no word is in
// flight, as the block itself does not enforce this. An anchor of 0, a month
// outside 1..12 or a day outside the month gives week_number 0 with invalid set.
`timescale 1ns / 1ps
`default_nettype none

module anchored_week_of_month import awm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                anchor_we,
	input  logic [ANCHOR_W-1:0] anchor_wdata,
	awm_date_if.sink            dates,
	awm_week_if.source          weeks
);

	logic [ANCHOR_W-1:0] anchor_q;

	logic   yr_valid, yr_ready;
	yr_s2_t yr_data;
	logic   cal_valid, cal_ready;
	cal_t   cal_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			anchor_q <= ANCHOR_RESET;
		else if (anchor_we)
			anchor_q <= anchor_wdata;
	end

	awm_year u_year (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dates.valid),
		.up_ready (dates.ready),
		.year     (dates.year),
		.month    (dates.month),
		.day      (dates.day),
		.dn_valid (yr_valid),
		.dn_ready (yr_ready),
		.dn_data  (yr_data)
	);

	awm_cal u_cal (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (yr_valid),
		.up_ready (yr_ready),
		.up_data  (yr_data),
		.dn_valid (cal_valid),
		.dn_ready (cal_ready),
		.dn_data  (cal_data)
	);

	awm_week u_week (
		.clk         (clk),
		.arst_n      (arst_n),
		.anchor      (anchor_q),
		.up_valid    (cal_valid),
		.up_ready    (cal_ready),
		.up_data     (cal_data),
		.dn_valid    (weeks.valid),
		.dn_ready    (weeks.ready),
		.week_number (weeks.week_number),
		.invalid     (weeks.invalid)
	);

endmodule

`default_nettype wire

// ===== rtl/awm_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awm_chk import awm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WEEK_W-1:0] week_number,
	input logic              invalid
);

	// an offered input word stays offered until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word withdrawn before it was taken");

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(week_number) && $stable(invalid))
		else $error("output word changed while stalled");

	// input backs up only when every stage is full and the output is stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the pipeline has room");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> week_number == 3'd0)
		else $error("invalid word carries a week number");

	a_week_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> week_number >= 3'd1 && week_number <= 3'd6)
		else $error("week number out of range");

endmodule

bind anchored_week_of_month awm_chk u_awm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (dates.valid),
	.in_ready    (dates.ready),
	.out_valid   (weeks.valid),
	.out_ready   (weeks.ready),
	.week_number (weeks.week_number),
	.invalid     (weeks.invalid)
);

`default_nettype wire
